// File: rtl/swm_pkg.sv
`default_nettype none

package swm_pkg;

  // Operation carried by an item through the chain of level cells
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INC  = 2'd1,
    OP_DEC  = 2'd2,
    OP_SEL  = 2'd3
  } swm_op_e;

  // Width of the window size register
  localparam int unsigned WinRegBits = 13;
  // Width of the sample and median ports
  localparam int unsigned PortBits   = 16;

endpackage

`default_nettype wire

// File: rtl/swm_level.sv
`default_nettype none

module swm_level #(
  parameter int unsigned LEVEL      = 1,
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned CNT_BITS   = 13
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  clr_i,
  input  wire logic [VALUE_BITS-1:0] clr_addr_i,
  input  wire swm_pkg::swm_op_e      op_i,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire logic [CNT_BITS-1:0]   rank_i,
  output swm_pkg::swm_op_e           op_o,
  output logic [VALUE_BITS-1:0]      value_o,
  output logic [CNT_BITS-1:0]        rank_o
);

  localparam logic [VALUE_BITS-1:0] BitMask = VALUE_BITS'(1) << (VALUE_BITS - LEVEL);

  logic [CNT_BITS-1:0]   mem_q [2**LEVEL];
  logic [CNT_BITS-1:0]   rd_q;
  swm_pkg::swm_op_e      op_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CNT_BITS-1:0]   rank_q;
  swm_pkg::swm_op_e      op_out_q;
  logic [VALUE_BITS-1:0] val_out_q, val_out_d;
  logic [CNT_BITS-1:0]   rank_out_q, rank_out_d;
  logic                  wr_en;
  logic [CNT_BITS-1:0]   wr_data;
  logic [LEVEL-1:0]      rd_addr;
  logic [LEVEL-1:0]      wr_addr;

  assign rd_addr = value_i[VALUE_BITS-1 -: LEVEL];
  assign wr_addr = val_q[VALUE_BITS-1 -: LEVEL];

  // node counts of this tree level
  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      mem_q[clr_addr_i[LEVEL-1:0]] <= '0;
    end else if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    val_q      <= value_i;
    rank_q     <= rank_i;
    val_out_q  <= val_out_d;
    rank_out_q <= rank_out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= swm_pkg::OP_NONE;
      op_out_q <= swm_pkg::OP_NONE;
    end else begin
      op_q     <= op_i;
      op_out_q <= op_q;
    end
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_data    = rd_q;
    val_out_d  = val_q;
    rank_out_d = rank_q;
    unique case (op_q)
      swm_pkg::OP_INC: begin
        wr_en   = 1'b1;
        wr_data = rd_q + CNT_BITS'(1);
      end
      swm_pkg::OP_DEC: begin
        wr_en   = 1'b1;
        wr_data = rd_q - CNT_BITS'(1);
      end
      swm_pkg::OP_SEL: begin
        // rd_q is the count of the left child
        if (rank_q > rd_q) begin
          rank_out_d = rank_q - rd_q;
          val_out_d  = val_q | BitMask;
        end
      end
      default: begin
      end
    endcase
  end

  assign op_o    = op_out_q;
  assign value_o = val_out_q;
  assign rank_o  = rank_out_q;

  a_dec_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == swm_pkg::OP_DEC) |-> (rd_q != '0))
    else $error("count underflow");

  a_inc_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == swm_pkg::OP_INC) |-> (rd_q != '1))
    else $error("count overflow");

  a_sel_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == swm_pkg::OP_SEL) |-> (rank_q != '0))
    else $error("select rank ran out");

  a_clr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i |-> (op_q == swm_pkg::OP_NONE))
    else $error("item in flight during clear");

endmodule

`default_nettype wire

// File: rtl/sliding_window_median_unit.sv
// Each accepted item walks the chain of VALUE_BITS level cells, each cell reading a count,
//   then updating it; the median then passes the result register to the output register.
// When the window is full, the next sample waits for the select walk and the median output
//   handshake; while the window fills, a sample is taken once the DEC to SEL steps are done.
// Reset: window size 3, window empty; the count tree is cleared by a sweep over its addresses
//   after reset and after each window size write, with no item taken meanwhile.
`default_nettype none

module sliding_window_median_unit #(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned WINDOW_MAX = 4096
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [swm_pkg::WinRegBits-1:0]     cfg_window_size_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [swm_pkg::PortBits-1:0]       sample_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [swm_pkg::PortBits-1:0]            median_o
);

  localparam int unsigned KW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned PW = $clog2(WINDOW_MAX);

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_DEC   = 9'b000000100,
    ST_GAP1  = 9'b000001000,
    ST_INC   = 9'b000010000,
    ST_GAP2  = 9'b000100000,
    ST_SEL   = 9'b001000000,
    ST_WAIT  = 9'b010000000,
    ST_PUT   = 9'b100000000
  } state_e;

  state_e                          state_q, state_d;
  logic [swm_pkg::WinRegBits-1:0]  ws_q, ws_d;
  logic [PW-1:0]                   wp_q, wp_d;
  logic [KW-1:0]                   fill_q, fill_d;
  logic [VALUE_BITS-1:0]           clr_q, clr_d;
  logic                            dec_q, dec_d;
  logic                            out_valid_q, out_valid_d;
  logic [swm_pkg::PortBits-1:0]    med_q, med_d;
  logic [VALUE_BITS-1:0]           res_q, res_d;
  logic [VALUE_BITS-1:0]           smp_q;
  logic [VALUE_BITS-1:0]           old_q;
  logic [VALUE_BITS-1:0]           ring_q [WINDOW_MAX];

  logic [31:0]                     ws32, k32;
  logic [KW-1:0]                   k;
  logic [KW-1:0]                   rank;
  logic                            accept;
  logic                            cfg_wr;
  logic                            full;

  swm_pkg::swm_op_e                op_c   [VALUE_BITS+1];
  logic [VALUE_BITS-1:0]           val_c  [VALUE_BITS+1];
  logic [KW-1:0]                   rank_c [VALUE_BITS+1];

  assign ws32 = 32'(ws_q);
  assign k32  = (ws32 == 32'd0) ? 32'd1 :
                (ws32 > 32'(WINDOW_MAX)) ? 32'(WINDOW_MAX) : ws32;
  assign k    = KW'(k32);
  assign rank = KW'((k32 + 32'd1) >> 1);
  assign full = (fill_q >= k);

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;

  // history ring: old entry read and new sample written in the accept cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_q[wp_q] <= VALUE_BITS'(sample_i);
      old_q        <= ring_q[wp_q];
      smp_q        <= VALUE_BITS'(sample_i);
    end
    res_q <= res_d;
    med_q <= med_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ws_q        <= swm_pkg::WinRegBits'(3);
      wp_q        <= '0;
      fill_q      <= '0;
      clr_q       <= '0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ws_q        <= ws_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      clr_q       <= clr_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ws_d        = ws_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    clr_d       = clr_q;
    dec_d       = dec_q;
    res_d       = res_q;
    med_d       = med_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + VALUE_BITS'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          dec_d   = full;
          wp_d    = ((32'(wp_q) + 32'd1) >= k32) ? '0 : wp_q + PW'(1);
          if (!full) begin
            fill_d = fill_q + KW'(1);
          end
          state_d = ST_DEC;
        end
      end
      ST_DEC:  state_d = ST_GAP1;
      ST_GAP1: state_d = ST_INC;
      ST_INC:  state_d = ST_GAP2;
      ST_GAP2: state_d = ST_SEL;
      ST_SEL:  state_d = full ? ST_WAIT : ST_IDLE;
      ST_WAIT: begin
        if (op_c[VALUE_BITS] == swm_pkg::OP_SEL) begin
          res_d   = val_c[VALUE_BITS];
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          med_d       = swm_pkg::PortBits'(res_q);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
    if (cfg_wr) begin
      ws_d    = cfg_window_size_i;
      wp_d    = '0;
      fill_d  = '0;
      clr_d   = '0;
      state_d = ST_CLEAR;
    end
  end

  always_comb begin
    op_c[0]   = swm_pkg::OP_NONE;
    val_c[0]  = smp_q;
    rank_c[0] = rank;
    if (state_q == ST_DEC && dec_q) begin
      op_c[0]  = swm_pkg::OP_DEC;
      val_c[0] = old_q;
    end else if (state_q == ST_INC) begin
      op_c[0]  = swm_pkg::OP_INC;
    end else if (state_q == ST_SEL && full) begin
      op_c[0]  = swm_pkg::OP_SEL;
      val_c[0] = '0;
    end
  end

  for (genvar g = 1; g <= VALUE_BITS; g++) begin : g_level
    swm_level #(
      .LEVEL      (g),
      .VALUE_BITS (VALUE_BITS),
      .CNT_BITS   (KW)
    ) u_level (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clr_i      (state_q == ST_CLEAR),
      .clr_addr_i (clr_q),
      .op_i       (op_c[g-1]),
      .value_i    (val_c[g-1]),
      .rank_i     (rank_c[g-1]),
      .op_o       (op_c[g]),
      .value_o    (val_c[g]),
      .rank_o     (rank_c[g])
    );
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = med_q;

  a_sel_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_c[VALUE_BITS] == swm_pkg::OP_SEL) |-> (state_q == ST_WAIT))
    else $error("select result arrived outside wait");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= k)
    else $error("fill count beyond window");

  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wp_q) < k32)
    else $error("write pointer beyond window");

endmodule

`default_nettype wire

// File: sim/tb_sliding_window_median_unit.sv
module tb_sliding_window_median_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ValueBits   = 16;
  localparam int unsigned WindowMax   = 4096;
  localparam int unsigned LeafBase    = 1 << ValueBits;
  localparam int unsigned TreeSize    = 2 << ValueBits;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned IdleOdds    = 8;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_valid   = 1'b0;
  logic                           cfg_ready_o;
  logic [swm_pkg::WinRegBits-1:0] cfg_window  = '0;
  logic                           in_valid    = 1'b0;
  logic                           in_ready_o;
  logic [swm_pkg::PortBits-1:0]   sample_d    = '0;
  logic                           out_valid_o;
  logic                           out_ready   = 1'b0;
  logic [swm_pkg::PortBits-1:0]   median_o;

  logic [swm_pkg::PortBits-1:0]   pending_samples[$];
  logic [swm_pkg::PortBits-1:0]   median_q[$];
  bit                             idle_on     = 1'b1;
  int unsigned                    send_gap    = 0;
  int unsigned                    stall_gap   = 0;
  int unsigned                    errors      = 0;

  // window state mirrored from the block
  logic [swm_pkg::WinRegBits-1:0] win_reg;
  logic [swm_pkg::PortBits-1:0]   ring[WindowMax];
  int unsigned                    ring_ptr;
  int unsigned                    fill;
  int unsigned                    counts[TreeSize];

  sliding_window_median_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_window_size_i (cfg_window),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .sample_i          (sample_d),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .median_o          (median_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned active_window();
    if (win_reg == 0) return 1;
    if (win_reg > WindowMax) return WindowMax;
    return 32'(win_reg);
  endfunction

  task automatic restart_window(logic [swm_pkg::WinRegBits-1:0] w);
    win_reg  = w;
    ring_ptr = 0;
    fill     = 0;
    foreach (counts[i]) counts[i] = 0;
  endtask

  task automatic count_adjust(int unsigned v, bit up);
    int unsigned node;
    node = LeafBase + v;
    while (node >= 1) begin
      if (up) counts[node]++;
      else counts[node]--;
      node >>= 1;
    end
  endtask

  function automatic logic [swm_pkg::PortBits-1:0] rank_value(int unsigned rank);
    int unsigned node;
    int unsigned r;
    node = 1;
    r = rank;
    for (int lvl = 0; lvl < ValueBits; lvl++) begin
      if (r <= counts[2 * node]) begin
        node = 2 * node;
      end else begin
        r -= counts[2 * node];
        node = 2 * node + 1;
      end
    end
    return swm_pkg::PortBits'(node - LeafBase);
  endfunction

  task automatic predict_median(logic [swm_pkg::PortBits-1:0] s);
    int unsigned k;
    int unsigned slot;
    k = active_window();
    slot = ring_ptr;
    if (slot >= k) slot = 0;
    if (fill >= k) count_adjust(32'(ring[slot]), 1'b0);
    count_adjust(32'(s), 1'b1);
    ring[slot] = s;
    slot++;
    ring_ptr = (slot >= k) ? 0 : slot;
    if (fill < k) fill++;
    if (fill >= k) median_q.push_back(rank_value((k + 1) / 2));
  endtask

  task automatic check_median(logic [swm_pkg::PortBits-1:0] got);
    logic [swm_pkg::PortBits-1:0] want;
    if (median_q.size() == 0) begin
      report_mismatch($sformatf("median %0d with none expected", got));
    end else begin
      want = median_q.pop_front();
      if (got !== want) report_mismatch($sformatf("median %0d, expected %0d", got, want));
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) predict_median(sample_d);
      if (!in_valid || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, IdleOdds - 1) == 0) begin
          send_gap = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_valid <= 1'b1;
          sample_d <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) check_median(median_o);
      if (stall_gap > 0) begin
        stall_gap--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, IdleOdds - 1) == 0) begin
        stall_gap = $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [swm_pkg::PortBits-1:0] rand_sample();
    unique case ($urandom_range(0, 3))
      0: return swm_pkg::PortBits'($urandom_range(0, 15));
      1: return swm_pkg::PortBits'($urandom_range(65520, 65535));
      2: return swm_pkg::PortBits'($urandom_range(32752, 32783));
      default: return swm_pkg::PortBits'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || median_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_window(logic [swm_pkg::WinRegBits-1:0] w);
    @(posedge clk_i);
    cfg_valid  <= 1'b1;
    cfg_window <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    restart_window(w);
  endtask

  task automatic run_phase(logic [swm_pkg::WinRegBits-1:0] w, int unsigned n, bit quiet);
    write_window(w);
    idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
    repeat (n) pending_samples.push_back(rand_sample());
    wait_idle();
  endtask

  initial begin
    restart_window(swm_pkg::WinRegBits'(3));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset window of 3: extremes, bit patterns, repeats, runs
    pending_samples = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE,
                        16'hAAAA, 16'h5555, 16'h5555, 16'h5555, 16'h0000, 16'h0000,
                        16'hFFFF, 16'hFFFF, 16'd100, 16'd99, 16'd98, 16'd97, 16'd98};
    wait_idle();

    run_phase(13'd0, 40, 1'b0);                // read as window of 1
    run_phase(13'd1, 40, 1'b0);
    run_phase(13'd2, 150, 1'b0);               // even size, lower median
    run_phase(13'd5, 3, 1'b0);                 // left partly filled
    run_phase(13'd5, 150, 1'b0);
    run_phase(13'd64, 200, 1'b0);
    run_phase(13'h1FFF, 30, 1'b0);             // saturates to the max window
    run_phase(13'd300, 420, 1'b0);
    run_phase(13'd3, 200, 1'b1);

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
rtl/swm_pkg.sv
rtl/swm_level.sv
rtl/sliding_window_median_unit.sv
sim/tb_sliding_window_median_unit.sv
